// ===== rtl/mlt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Mutex lock table package
// Shared constants, codes and the item type passed from the front end to the
// back end.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int NUM_LOCKS   = 64;
    localparam int MAX_WAITERS = 16;
    localparam int THREAD_BITS = 8;
    localparam int IDX_W       = 6;
    localparam int HEAD_W      = $clog2(MAX_WAITERS);
    localparam int FILL_W      = $clog2(MAX_WAITERS + 1);
    localparam int SLOT_W      = IDX_W + HEAD_W;
    localparam int QDEPTH      = NUM_LOCKS * MAX_WAITERS;
    localparam int FIFO_DEPTH  = 2;

    typedef enum logic [2:0] {
        FN_LOCK    = 3'd0,
        FN_TRYLOCK = 3'd1,
        FN_UNLOCK  = 3'd2,
        FN_CREATE  = 3'd3,
        FN_DESTROY = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_BUSY        = 3'd2,
        ST_INVALID     = 3'd3,
        ST_NO_RES      = 3'd4,
        ST_NOT_OWNER   = 3'd5,
        ST_WOULD_BLOCK = 3'd6
    } status_t;

    localparam logic [1:0] KIND_ERRCHK    = 2'd0;
    localparam logic [1:0] KIND_RECURSIVE = 2'd1;
    localparam logic [1:0] KIND_NORMAL    = 2'd2;
    localparam logic [1:0] KIND_ADAPTIVE  = 2'd3;

    typedef enum logic [2:0] {
        OP_DONE    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_DESTROY = 3'd2,
        OP_LOCK    = 3'd3,
        OP_UNLOCK  = 3'd4
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic                   no_wait;
        status_t                early_status;
        logic [IDX_W-1:0]       idx;
        logic [THREAD_BITS-1:0] thr;
        logic [1:0]             kind;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/mlt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Mutex lock table front end
// Accepts request items, decodes the function and lock kind, marks the requests
// that need no table state as done, and holds all items in a short queue.
// ----------------------------------------------------------------------------
module mlt_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [2:0]                     s_func,
    input  wire logic [5:0]                     s_lock_index,
    input  wire logic [mlt_pkg::THREAD_BITS-1:0] s_thread_id,
    input  wire logic [2:0]                     s_lock_kind,
    output logic                                cmd_valid,
    input  wire logic                           cmd_ready,
    output mlt_pkg::cmd_t                       cmd
);
    import mlt_pkg::*;

    cmd_t        fifo_mem [FIFO_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    cmd_t        dec;
    logic        push, pop;

    always_comb begin
        dec.op           = OP_DONE;
        dec.no_wait      = (s_func == FN_TRYLOCK);
        dec.early_status = ST_INVALID;
        dec.idx          = s_lock_index;
        dec.thr          = s_thread_id;
        dec.kind         = (s_lock_kind == 3'd0) ? KIND_ERRCHK : 2'(s_lock_kind - 3'd1);
        case (s_func)
            FN_LOCK, FN_TRYLOCK: dec.op = OP_LOCK;
            FN_UNLOCK:           dec.op = OP_UNLOCK;
            FN_DESTROY:          dec.op = OP_DESTROY;
            FN_CREATE: begin
                if (s_lock_kind > 3'd4) begin
                    dec.op = OP_DONE;
                end else begin
                    dec.op = OP_CREATE;
                end
            end
            default:             dec.op = OP_DONE;
        endcase
    end

    assign s_ready   = (count_reg != 2'(FIFO_DEPTH));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = fifo_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= dec;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mlt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Mutex lock table back end
// Reads the addressed entry, scans its waiter queue one slot a cycle, writes
// the entry back and registers the result item.
// ----------------------------------------------------------------------------
module mlt_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cmd_valid,
    output logic                                cmd_ready,
    input  mlt_pkg::cmd_t                       cmd,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [2:0]                          m_status,
    output logic                                m_wake_valid,
    output logic [mlt_pkg::THREAD_BITS-1:0]     m_wake_thread,
    output logic [31:0]                         m_hold_count
);
    import mlt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_WAKE  = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    logic [NUM_LOCKS-1:0]   entry_valid_reg;
    logic [NUM_LOCKS-1:0]   owner_valid_reg;
    logic [NUM_LOCKS-1:0]   granted_reg;
    logic [1:0]             kind_mem   [NUM_LOCKS];
    logic [THREAD_BITS-1:0] owner_mem  [NUM_LOCKS];
    logic [31:0]            rec_mem    [NUM_LOCKS];
    logic [HEAD_W-1:0]      head_mem   [NUM_LOCKS];
    logic [FILL_W-1:0]      fill_mem   [NUM_LOCKS];
    logic [THREAD_BITS-1:0] queue_mem  [QDEPTH];

    state_t                 state_reg;
    cmd_t                   cur_reg;
    logic [1:0]             kind_reg;
    logic [THREAD_BITS-1:0] owner_reg;
    logic [31:0]            rec_reg;
    logic [HEAD_W-1:0]      head_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      pos_reg;
    logic [THREAD_BITS-1:0] qrd_reg;
    status_t                res_status_reg;
    logic                   res_wv_reg;
    logic [THREAD_BITS-1:0] res_wt_reg;
    logic                   out_valid_reg;
    status_t                out_status_reg;
    logic                   out_wv_reg;
    logic [THREAD_BITS-1:0] out_wt_reg;
    logic [31:0]            out_hold_reg;

    logic [SLOT_W-1:0]      rd_slot;
    logic [SLOT_W-1:0]      wr_slot;
    logic [FILL_W-1:0]      rd_off;
    logic [HEAD_W-1:0]      slot_off;
    logic [HEAD_W-1:0]      wr_off;
    logic                   ev, ov, gb;
    logic                   found;
    logic                   exec_scan, exec_wake;
    logic                   resp_go;

    assign ev = entry_valid_reg[cur_reg.idx];
    assign ov = owner_valid_reg[cur_reg.idx];
    assign gb = granted_reg[cur_reg.idx];

    assign cmd_ready     = (state_reg == S_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_wake_valid  = out_wv_reg;
    assign m_wake_thread = out_wt_reg;
    assign m_hold_count  = out_hold_reg;

    assign rd_off   = (state_reg == S_SCAN) ? pos_reg + FILL_W'(1) : pos_reg;
    assign slot_off = head_reg + HEAD_W'(rd_off);
    assign rd_slot  = {cur_reg.idx, slot_off};
    assign wr_off   = head_reg + HEAD_W'(fill_reg);
    assign wr_slot  = {cur_reg.idx, wr_off};

    assign exec_wake = (cur_reg.op == OP_UNLOCK) && ev && ov && (owner_reg == cur_reg.thr)
                       && (rec_reg == 32'd1) && (fill_reg != '0);
    assign exec_scan = (cur_reg.op == OP_LOCK) && ev && ov && (owner_reg != cur_reg.thr)
                       && !cur_reg.no_wait;
    assign resp_go   = (state_reg == S_RESP) && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (state_reg == S_SCAN || state_reg == S_EXEC) begin
            qrd_reg <= queue_mem[rd_slot];
        end
    end

    assign found = (qrd_reg == cur_reg.thr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            owner_valid_reg <= '0;
            granted_reg     <= '0;
        end else begin
            if (resp_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        cur_reg   <= cmd;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    kind_reg  <= kind_mem[cur_reg.idx];
                    owner_reg <= owner_mem[cur_reg.idx];
                    rec_reg   <= rec_mem[cur_reg.idx];
                    head_reg  <= head_mem[cur_reg.idx];
                    fill_reg  <= fill_mem[cur_reg.idx];
                    pos_reg   <= '0;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    res_wv_reg <= 1'b0;
                    res_wt_reg <= '0;
                    if (exec_scan) begin
                        state_reg <= S_SCAN;
                    end else if (exec_wake) begin
                        state_reg <= S_WAKE;
                    end else begin
                        state_reg <= S_RESP;
                    end
                    case (cur_reg.op)
                        OP_CREATE: begin
                            if (ev) begin
                                res_status_reg <= ST_NO_RES;
                                rec_reg        <= rec_reg;
                            end else begin
                                entry_valid_reg[cur_reg.idx] <= 1'b1;
                                owner_valid_reg[cur_reg.idx] <= 1'b0;
                                granted_reg[cur_reg.idx]     <= 1'b0;
                                kind_mem[cur_reg.idx]        <= cur_reg.kind;
                                rec_mem[cur_reg.idx]         <= '0;
                                head_mem[cur_reg.idx]        <= '0;
                                fill_mem[cur_reg.idx]        <= '0;
                                rec_reg                      <= '0;
                                res_status_reg               <= ST_OK;
                            end
                        end
                        OP_DESTROY: begin
                            if (!ev) begin
                                res_status_reg <= ST_NOT_FOUND;
                            end else if (ov || gb || fill_reg != '0) begin
                                res_status_reg <= ST_BUSY;
                            end else begin
                                entry_valid_reg[cur_reg.idx] <= 1'b0;
                                rec_mem[cur_reg.idx]         <= '0;
                                res_status_reg               <= ST_OK;
                            end
                        end
                        OP_UNLOCK: begin
                            if (!ev) begin
                                res_status_reg <= ST_NOT_FOUND;
                            end else if (!ov || owner_reg != cur_reg.thr) begin
                                res_status_reg <= ST_NOT_OWNER;
                            end else if (rec_reg == 32'd0) begin
                                res_status_reg <= ST_INVALID;
                            end else if (rec_reg != 32'd1) begin
                                rec_reg              <= rec_reg - 32'd1;
                                rec_mem[cur_reg.idx] <= rec_reg - 32'd1;
                                res_status_reg       <= ST_OK;
                            end else if (fill_reg == '0) begin
                                owner_valid_reg[cur_reg.idx] <= 1'b0;
                                granted_reg[cur_reg.idx]     <= 1'b0;
                                rec_reg                      <= '0;
                                rec_mem[cur_reg.idx]         <= '0;
                                res_status_reg               <= ST_OK;
                            end else begin
                                res_status_reg <= ST_OK;
                            end
                        end
                        OP_LOCK: begin
                            if (!ev) begin
                                res_status_reg <= ST_NOT_FOUND;
                            end else if (!ov) begin
                                owner_valid_reg[cur_reg.idx] <= 1'b1;
                                owner_mem[cur_reg.idx]       <= cur_reg.thr;
                                rec_mem[cur_reg.idx]         <= 32'd1;
                                rec_reg                      <= 32'd1;
                                res_status_reg               <= ST_OK;
                            end else if (owner_reg == cur_reg.thr) begin
                                if (gb) begin
                                    granted_reg[cur_reg.idx] <= 1'b0;
                                    res_status_reg           <= ST_OK;
                                end else if (kind_reg == KIND_RECURSIVE ||
                                             (kind_reg == KIND_NORMAL && !cur_reg.no_wait)) begin
                                    if (rec_reg == 32'hFFFF_FFFF) begin
                                        res_status_reg <= ST_NO_RES;
                                    end else begin
                                        rec_reg              <= rec_reg + 32'd1;
                                        rec_mem[cur_reg.idx] <= rec_reg + 32'd1;
                                        res_status_reg       <= ST_OK;
                                    end
                                end else if (kind_reg == KIND_ADAPTIVE && !cur_reg.no_wait) begin
                                    res_status_reg <= ST_OK;
                                end else begin
                                    res_status_reg <= cur_reg.no_wait ? ST_BUSY : ST_INVALID;
                                end
                            end else if (cur_reg.no_wait) begin
                                res_status_reg <= ST_BUSY;
                            end else begin
                                pos_reg <= '0;
                            end
                        end
                        default: begin
                            res_status_reg <= cur_reg.early_status;
                        end
                    endcase
                end
                S_SCAN: begin
                    // qrd_reg holds the slot at pos_reg; the next is being read.
                    if (pos_reg < fill_reg && found) begin
                        res_status_reg <= ST_WOULD_BLOCK;
                        state_reg      <= S_RESP;
                    end else if (pos_reg >= fill_reg) begin
                        if (fill_reg >= FILL_W'(MAX_WAITERS)) begin
                            res_status_reg <= ST_NO_RES;
                        end else begin
                            queue_mem[wr_slot]    <= cur_reg.thr;
                            fill_mem[cur_reg.idx] <= fill_reg + FILL_W'(1);
                            res_status_reg        <= ST_WOULD_BLOCK;
                        end
                        state_reg <= S_RESP;
                    end else begin
                        pos_reg <= pos_reg + FILL_W'(1);
                    end
                end
                S_WAKE: begin
                    // qrd_reg holds the front waiter, read in the cycle before.
                    owner_mem[cur_reg.idx]   <= qrd_reg;
                    granted_reg[cur_reg.idx] <= 1'b1;
                    rec_reg                  <= 32'd1;
                    rec_mem[cur_reg.idx]     <= 32'd1;
                    head_mem[cur_reg.idx]    <= head_reg + HEAD_W'(1);
                    fill_mem[cur_reg.idx]    <= fill_reg - FILL_W'(1);
                    res_wv_reg               <= 1'b1;
                    res_wt_reg               <= qrd_reg;
                    state_reg                <= S_RESP;
                end
                S_RESP: begin
                    if (resp_go) begin
                        out_status_reg <= res_status_reg;
                        out_wv_reg     <= res_wv_reg;
                        out_wt_reg     <= res_wt_reg;
                        out_hold_reg   <= entry_valid_reg[cur_reg.idx] ? rec_reg : 32'd0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mutex_lock_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Mutex lock table unit
// Sixty-four lock entries with owner, recursion count and waiter queues.
// ----------------------------------------------------------------------------
// Each request item yields one result item. The back end steps each request
// through its read, execute and response states and takes a new request only
// once it is idle again; the result waits in an output register while the
// next request is worked on, and the back end holds in its response state
// while an earlier result has not been taken. A blocking lock by a thread that
// is not the owner also passes through a scan state that reads one queued
// waiter slot at a time through a single registered read port, and an unlock
// that hands the entry to a waiter passes through a wake state. A two-entry
// queue sits between the decoder and the back end. No clearing pass is needed after reset.
module mutex_lock_table_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [2:0]                      s_func,
    input  wire logic [5:0]                      s_lock_index,
    input  wire logic [mlt_pkg::THREAD_BITS-1:0] s_thread_id,
    input  wire logic [2:0]                      s_lock_kind,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [2:0]                           m_status,
    output logic                                 m_wake_valid,
    output logic [mlt_pkg::THREAD_BITS-1:0]      m_wake_thread,
    output logic [31:0]                          m_hold_count
);
    import mlt_pkg::*;

    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    mlt_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_func, .s_lock_index,
        .s_thread_id, .s_lock_kind, .cmd_valid, .cmd_ready, .cmd
    );

    mlt_back u_back (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd, .m_valid, .m_ready,
        .m_status, .m_wake_valid, .m_wake_thread, .m_hold_count
    );

endmodule
`default_nettype wire
